FILE: rtl/core/qoi_enc_pkg.sv
// Package for the QOI-style image encoder core.
// Holds the channel payload types, the internal packet descriptor, the op codes and the hash.
// No dependencies.
package qoi_enc_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_pixel;
      logic       end_of_stream;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_INDEX,
      BODY_RGB,
      BODY_RGBA
   } body_type;

   typedef enum logic [1:0] {
      SEG_HDR,
      SEG_RUN,
      SEG_BODY,
      SEG_MARK
   } seg_type;

   typedef struct packed {
      logic            has_hdr;
      logic            has_run;
      logic [7:0]      run_byte;
      body_type        body;
      req_payload_type pixel;
      logic [5:0]      hash;
      logic            has_mark;
      logic [15:0]     width;
      logic [15:0]     height;
   } pkt_type;

   localparam req_payload_type PIXEL_RESET = 32'h0000_00FF;

   localparam logic [7:0] OP_RUN     = 8'hC0;
   localparam logic [7:0] OP_RGB     = 8'hFE;
   localparam logic [7:0] OP_RGBA    = 8'hFF;
   localparam logic [5:0] RUN_MAX    = 6'd62;
   localparam logic [7:0] MAGIC_Q    = 8'h71;
   localparam logic [7:0] MAGIC_O    = 8'h6F;
   localparam logic [7:0] MAGIC_I    = 8'h69;
   localparam logic [7:0] MAGIC_F    = 8'h66;
   localparam logic [7:0] CHANNELS   = 8'h03;
   localparam logic [7:0] COLORSPACE = 8'h00;
   localparam logic [7:0] MARK_FINAL = 8'h01;

   localparam logic [3:0] HDR_LAST  = 4'd13;
   localparam logic [3:0] RGB_LAST  = 4'd3;
   localparam logic [3:0] RGBA_LAST = 4'd4;
   localparam logic [3:0] MARK_LAST = 4'd7;

   function automatic logic [5:0] pixel_hash(input req_payload_type p);
      logic [12:0] sum;
      sum = 13'(p.red) * 13'd3 + 13'(p.green) * 13'd5 + 13'(p.blue) * 13'd7
            + 13'(p.alpha) * 13'd11;
      return sum[5:0];
   endfunction

endpackage

FILE: rtl/core/qoi_enc_serializer.sv
// Byte serializer of the QOI-style image encoder core.
// Walks one packet descriptor through header, run, body and end marker segments.
// Depends on qoi_enc_pkg.
module qoi_enc_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pkt_valid,
   input  qoi_enc_pkg::pkt_type        pkt,
   output logic                        pkt_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output qoi_enc_pkg::rsp_payload_type rsp_payload
);
   import qoi_enc_pkg::*;

   pkt_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   seg_type    seg_ff, seg_in;
   logic [3:0] cnt_ff, cnt_in;

   logic [3:0] seg_last_idx;
   logic       seg_end;
   logic       has_next;
   seg_type    next_seg;
   seg_type    first_seg;
   logic       byte_xfer;
   logic       pkt_done;
   logic [7:0] byte_val;

   always_comb begin
      unique case (seg_ff)
         SEG_HDR:  seg_last_idx = HDR_LAST;
         SEG_RUN:  seg_last_idx = 4'd0;
         SEG_BODY: begin
            unique case (cur_ff.body)
               BODY_RGB:  seg_last_idx = RGB_LAST;
               BODY_RGBA: seg_last_idx = RGBA_LAST;
               default:   seg_last_idx = 4'd0;
            endcase
         end
         SEG_MARK: seg_last_idx = MARK_LAST;
         default:  seg_last_idx = 4'd0;
      endcase
   end

   assign seg_end = (cnt_ff == seg_last_idx);

   always_comb begin
      has_next = 1'b1;
      next_seg = SEG_MARK;
      priority if (seg_ff == SEG_HDR && cur_ff.has_run) begin
         next_seg = SEG_RUN;
      end else if ((seg_ff == SEG_HDR || seg_ff == SEG_RUN) && cur_ff.body != BODY_NONE) begin
         next_seg = SEG_BODY;
      end else if (seg_ff != SEG_MARK && cur_ff.has_mark) begin
         next_seg = SEG_MARK;
      end else begin
         has_next = 1'b0;
      end
   end

   always_comb begin
      priority if (pkt.has_hdr) begin
         first_seg = SEG_HDR;
      end else if (pkt.has_run) begin
         first_seg = SEG_RUN;
      end else if (pkt.body != BODY_NONE) begin
         first_seg = SEG_BODY;
      end else begin
         first_seg = SEG_MARK;
      end
   end

   assign byte_xfer = cur_valid_ff && !rsp_stall;
   assign pkt_done  = byte_xfer && seg_end && !has_next;
   assign pkt_take  = !cur_valid_ff || pkt_done;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      seg_in       = seg_ff;
      cnt_in       = cnt_ff;
      if (pkt_take) begin
         cur_valid_in = pkt_valid;
         if (pkt_valid) begin
            cur_in = pkt;
            seg_in = first_seg;
            cnt_in = 4'd0;
         end
      end else if (byte_xfer) begin
         if (seg_end) begin
            seg_in = next_seg;
            cnt_in = 4'd0;
         end else begin
            cnt_in = cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
      cur_ff <= cur_in;
      seg_ff <= seg_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      byte_val = 8'h00;
      unique case (seg_ff)
         SEG_HDR: begin
            unique case (cnt_ff)
               4'd0:    byte_val = MAGIC_Q;
               4'd1:    byte_val = MAGIC_O;
               4'd2:    byte_val = MAGIC_I;
               4'd3:    byte_val = MAGIC_F;
               4'd6:    byte_val = cur_ff.width[15:8];
               4'd7:    byte_val = cur_ff.width[7:0];
               4'd10:   byte_val = cur_ff.height[15:8];
               4'd11:   byte_val = cur_ff.height[7:0];
               4'd12:   byte_val = CHANNELS;
               4'd13:   byte_val = COLORSPACE;
               default: byte_val = 8'h00;
            endcase
         end
         SEG_RUN: byte_val = cur_ff.run_byte;
         SEG_BODY: begin
            if (cur_ff.body == BODY_INDEX) begin
               byte_val = {2'b00, cur_ff.hash};
            end else begin
               unique case (cnt_ff)
                  4'd0:    byte_val = (cur_ff.body == BODY_RGB) ? OP_RGB : OP_RGBA;
                  4'd1:    byte_val = cur_ff.pixel.red;
                  4'd2:    byte_val = cur_ff.pixel.green;
                  4'd3:    byte_val = cur_ff.pixel.blue;
                  default: byte_val = cur_ff.pixel.alpha;
               endcase
            end
         end
         SEG_MARK: byte_val = (cnt_ff == MARK_LAST) ? MARK_FINAL : 8'h00;
         default:  byte_val = 8'h00;
      endcase
   end

   assign rsp_valid                 = cur_valid_ff;
   assign rsp_payload.out_byte      = byte_val;
   assign rsp_payload.last_of_pixel = seg_end && !has_next;
   assign rsp_payload.end_of_stream = (seg_ff == SEG_MARK) && (cnt_ff == MARK_LAST);

endmodule

FILE: rtl/core/qoi_image_encoder_core.sv
// Top level of the QOI-style image encoder core: pixel stage, color index table, packet queue.
// Depends on qoi_enc_pkg and qoi_enc_serializer.
//
//   Channel   Direction  Ports                               Transfer when
//   req       in         req_valid, req_stall, req_payload   req_valid and not req_stall
//   rsp       out        rsp_valid, rsp_stall, rsp_payload   rsp_valid and not rsp_stall
//   csr       in         csr_wr_en, csr_index, csr_wdata     csr_wr_en
//
// A pixel that only extends a run is taken every cycle unless the pixel ahead of it waits for the packet register.
// A pixel that produces n bytes sends them one at a time over the single byte output lane.
// Its first byte is registered in the pixel stage, the packet register and the serializer's packet register.
// Up to two packets wait between the pixel stage and the output, so input flows on during output.
// Reset is synchronous and takes effect at once; the index table uses per-entry valid bits.
module qoi_image_encoder_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  qoi_enc_pkg::req_payload_type              req_payload,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output qoi_enc_pkg::rsp_payload_type              rsp_payload,
   input  logic                                      csr_wr_en,
   input  logic [qoi_enc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [qoi_enc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import qoi_enc_pkg::*;

   logic [15:0]     width_ff, width_in;
   logic [15:0]     height_ff, height_in;
   logic [31:0]     total_ff, total_in;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type pix_ff;
   logic [5:0]      hash_ff;
   logic [31:0]     tbl_rd_ff;
   logic            rd_valid_ff, rd_valid_in;
   logic            fwd_ff, fwd_in;
   req_payload_type fwd_pix_ff;

   logic [31:0]     tbl_mem [64];
   logic [63:0]     tbl_vld_ff, tbl_vld_in;

   req_payload_type prev_ff, prev_in;
   logic [5:0]      run_ff, run_in;
   logic [31:0]     count_ff, count_in;
   logic            hdr_sent_ff, hdr_sent_in;

   pkt_type         pkt_ff, pkt_in;
   logic            pkt_valid_ff, pkt_valid_in;
   logic            pkt_take;

   logic            req_xfer;
   logic [5:0]      h_in;
   logic            s1_fire;
   logic            s1_load;
   logic [31:0]     count_next;
   logic            last;
   logic            same;
   logic [5:0]      run_inc;
   logic [5:0]      run_new;
   logic [31:0]     tbl_val;
   logic            hit;
   logic            tbl_wr;
   logic            nonempty;
   pkt_type         s1_pkt;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   assign total_in = 32'(width_in) * 32'(height_in);

   assign req_xfer = req_valid && !req_stall;
   assign h_in     = pixel_hash(req_payload);

   assign count_next = count_ff + 32'd1;
   assign last       = (count_next == total_ff);
   assign same       = (pix_ff == prev_ff);
   assign run_inc    = run_ff + 6'd1;
   assign tbl_val    = !rd_valid_ff ? 32'd0 : (fwd_ff ? fwd_pix_ff : tbl_rd_ff);
   assign hit        = (tbl_val == pix_ff);

   always_comb begin
      s1_pkt          = '0;
      s1_pkt.has_hdr  = !hdr_sent_ff;
      s1_pkt.pixel    = pix_ff;
      s1_pkt.hash     = hash_ff;
      s1_pkt.has_mark = last;
      s1_pkt.width    = width_ff;
      s1_pkt.height   = height_ff;
      s1_pkt.body     = BODY_NONE;
      tbl_wr          = 1'b0;
      run_new         = 6'd0;
      if (same) begin
         if (run_inc == RUN_MAX) begin
            s1_pkt.has_run  = 1'b1;
            s1_pkt.run_byte = OP_RUN | {2'b00, run_inc - 6'd1};
         end else begin
            run_new = run_inc;
         end
      end else begin
         s1_pkt.has_run  = (run_ff != 6'd0);
         s1_pkt.run_byte = OP_RUN | {2'b00, run_ff - 6'd1};
         if (hit) begin
            s1_pkt.body = BODY_INDEX;
         end else begin
            tbl_wr      = 1'b1;
            s1_pkt.body = (pix_ff.alpha == prev_ff.alpha) ? BODY_RGB : BODY_RGBA;
         end
      end
      if (last && run_new != 6'd0) begin
         s1_pkt.has_run  = 1'b1;
         s1_pkt.run_byte = OP_RUN | {2'b00, run_new - 6'd1};
      end
   end

   assign nonempty = s1_pkt.has_hdr || s1_pkt.has_run || s1_pkt.body != BODY_NONE || last;
   assign s1_fire  = s1_valid_ff && (!nonempty || !pkt_valid_ff || pkt_take);
   assign s1_load  = s1_fire && nonempty;

   assign req_stall = s1_valid_ff && !s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // The table entry of the next pixel is read while the current pixel may write
   // or clear it, so the write is forwarded and an image end hides the old contents.
   always_comb begin
      fwd_in      = s1_fire && tbl_wr && !last && (hash_ff == h_in);
      rd_valid_in = (s1_fire && last) ? 1'b0 : (fwd_in || tbl_vld_ff[h_in]);
   end

   always_comb begin
      tbl_vld_in = tbl_vld_ff;
      if (s1_fire && last) begin
         tbl_vld_in = '0;
      end else if (s1_fire && tbl_wr) begin
         tbl_vld_in[hash_ff] = 1'b1;
      end
   end

   always_comb begin
      prev_in     = prev_ff;
      run_in      = run_ff;
      count_in    = count_ff;
      hdr_sent_in = hdr_sent_ff;
      if (s1_fire) begin
         if (last) begin
            prev_in     = PIXEL_RESET;
            run_in      = 6'd0;
            count_in    = 32'd0;
            hdr_sent_in = 1'b0;
         end else begin
            prev_in     = pix_ff;
            run_in      = run_new;
            count_in    = count_next;
            hdr_sent_in = 1'b1;
         end
      end
   end

   always_comb begin
      pkt_in       = pkt_ff;
      pkt_valid_in = pkt_valid_ff;
      if (s1_load) begin
         pkt_in       = s1_pkt;
         pkt_valid_in = 1'b1;
      end else if (pkt_take) begin
         pkt_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_wr && s1_fire) begin
         tbl_mem[hash_ff] <= pix_ff;
      end
      if (req_xfer) begin
         tbl_rd_ff <= tbl_mem[h_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 16'd1;
         height_ff    <= 16'd1;
         total_ff     <= 32'd1;
         s1_valid_ff  <= 1'b0;
         tbl_vld_ff   <= '0;
         prev_ff      <= PIXEL_RESET;
         run_ff       <= 6'd0;
         count_ff     <= 32'd0;
         hdr_sent_ff  <= 1'b0;
         pkt_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         s1_valid_ff  <= s1_valid_in;
         tbl_vld_ff   <= tbl_vld_in;
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         count_ff     <= count_in;
         hdr_sent_ff  <= hdr_sent_in;
         pkt_valid_ff <= pkt_valid_in;
      end
      pkt_ff   <= pkt_in;
      if (req_xfer) begin
         pix_ff      <= req_payload;
         hash_ff     <= h_in;
         rd_valid_ff <= rd_valid_in;
         fwd_ff      <= fwd_in;
         fwd_pix_ff  <= pix_ff;
      end
   end

   qoi_enc_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .pkt_valid   (pkt_valid_ff),
      .pkt         (pkt_ff),
      .pkt_take    (pkt_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/qoi_enc_checker.sv
// Port-level checker for the QOI-style image encoder core, bound to the top level.
// Depends on qoi_enc_pkg and qoi_image_encoder_core.
module qoi_enc_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input qoi_enc_pkg::rsp_payload_type              rsp_payload
);
   import qoi_enc_pkg::*;

   // An output byte that is not taken stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled output byte changed");

   // The end of the stream is always the last byte of its pixel and carries the final code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_stream |->
         rsp_payload.last_of_pixel && rsp_payload.out_byte == MARK_FINAL)
      else $error("end of stream on a wrong byte");

   // The byte after an end marker opens the next image header.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.end_of_stream |=>
         !rsp_valid || rsp_payload.out_byte == MAGIC_Q)
      else $error("next image does not start with a header");

   // Nothing leaves the block in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind qoi_image_encoder_core qoi_enc_checker u_qoi_enc_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for qoi_image_encoder_core: drives RGBA pixels, predicts the byte stream.
// An in-bench encoder predicts each byte; the result monitor checks every transfer in order.
// Depends on qoi_enc_pkg and the encoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qoi_enc_pkg::*;

   localparam int WATCHDOG_CYCLES = 500000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PIXELS   = 400;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_payload_type            rsp_payload;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // Encoder state as the block should hold it.
   logic [15:0]     img_width;
   logic [15:0]     img_height;
   req_payload_type prev_px;
   req_payload_type color_cache [64];
   logic [5:0]      run_len;
   logic [31:0]     px_count;
   bit              header_done;

   rsp_payload_type expected_bytes [$];
   rsp_payload_type want_byte;
   int              mismatches;
   int              cycle_count;
   bit              idle_on;
   int              rsp_hold_cycles;

   qoi_image_encoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == WATCHDOG_CYCLES) begin
         $display("Timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, expected_bytes.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void clear_image();
      prev_px     = PIXEL_RESET;
      run_len     = '0;
      px_count    = '0;
      header_done = 1'b0;
      foreach (color_cache[i]) color_cache[i] = '0;
   endfunction

   function automatic void push_byte(input logic [7:0] value);
      rsp_payload_type b;
      b.out_byte      = value;
      b.last_of_pixel = 1'b0;
      b.end_of_stream = 1'b0;
      expected_bytes.push_back(b);
   endfunction

   function automatic void flush_run();
      if (run_len != 0) begin
         push_byte(OP_RUN | {2'b00, run_len - 6'd1});
         run_len = '0;
      end
   endfunction

   function automatic void encode_pixel(input req_payload_type px);
      int          queued_before;
      int          sum;
      logic [5:0]  slot;
      logic [31:0] pixel_total;
      bit          image_done;
      queued_before = expected_bytes.size();
      if (!header_done) begin
         push_byte(MAGIC_Q);
         push_byte(MAGIC_O);
         push_byte(MAGIC_I);
         push_byte(MAGIC_F);
         push_byte(8'h00);
         push_byte(8'h00);
         push_byte(img_width[15:8]);
         push_byte(img_width[7:0]);
         push_byte(8'h00);
         push_byte(8'h00);
         push_byte(img_height[15:8]);
         push_byte(img_height[7:0]);
         push_byte(CHANNELS);
         push_byte(COLORSPACE);
         header_done = 1'b1;
      end
      px_count    = px_count + 32'd1;
      pixel_total = {16'h0000, img_width} * {16'h0000, img_height};
      image_done  = (px_count == pixel_total);
      if (px == prev_px) begin
         run_len = run_len + 6'd1;
         if (run_len == RUN_MAX) flush_run();
      end else begin
         flush_run();
         sum  = 3 * int'(px.red) + 5 * int'(px.green) + 7 * int'(px.blue)
                + 11 * int'(px.alpha);
         slot = sum[5:0];
         if (color_cache[slot] == px) begin
            push_byte({2'b00, slot});
         end else begin
            color_cache[slot] = px;
            push_byte((px.alpha == prev_px.alpha) ? OP_RGB : OP_RGBA);
            push_byte(px.red);
            push_byte(px.green);
            push_byte(px.blue);
            if (px.alpha != prev_px.alpha) push_byte(px.alpha);
         end
         prev_px = px;
      end
      if (image_done) begin
         flush_run();
         repeat (7) push_byte(8'h00);
         push_byte(MARK_FINAL);
         expected_bytes[$].end_of_stream = 1'b1;
         clear_image();
      end
      if (expected_bytes.size() > queued_before) expected_bytes[$].last_of_pixel = 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Result monitor: every transfer is compared with the oldest expected byte.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h", rsp_payload.out_byte));
         end else begin
            want_byte = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== want_byte.out_byte ||
                rsp_payload.last_of_pixel !== want_byte.last_of_pixel ||
                rsp_payload.end_of_stream !== want_byte.end_of_stream) begin
               report_mismatch($sformatf(
                  "byte exp %h got %h, last_of_pixel exp %b got %b, end exp %b got %b",
                  want_byte.out_byte, rsp_payload.out_byte,
                  want_byte.last_of_pixel, rsp_payload.last_of_pixel,
                  want_byte.end_of_stream, rsp_payload.end_of_stream));
            end
         end
      end
   end

   // Result receiver: random stall before each transfer while idle_on is set, plus an optional long hold.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = idle_on ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_pixel(input req_payload_type px);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      repeat (gap) @(negedge clock);
      req_valid   = 1'b1;
      req_payload = px;
      do @(posedge clock); while (req_stall);
      encode_pixel(px);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (index == CSR_WIDTH) img_width = value;
      else img_height = value;
   endtask

   task automatic test_reset_values();
      send_pixel(PIXEL_RESET);
      send_pixel(32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_dimension_extremes();
      write_csr(CSR_WIDTH, 16'hFFFF);
      write_csr(CSR_HEIGHT, 16'hFFFF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h5555_5555);
      send_pixel(32'hAAAA_AAAA);
      wait_drained();
      write_csr(CSR_WIDTH, 16'd2);
      write_csr(CSR_HEIGHT, 16'd3);
      send_pixel(32'h0102_0304);
      send_pixel(32'h0102_0304);
      send_pixel(32'h8040_2010);
      wait_drained();
      write_csr(CSR_WIDTH, 16'd1);
      write_csr(CSR_HEIGHT, 16'hFFFF);
      send_pixel(32'h7F80_7F80);
      send_pixel(32'h0000_00FE);
      wait_drained();
      write_csr(CSR_HEIGHT, 16'd4);
      send_pixel(32'h0000_00FE);
      send_pixel(32'hFF00_FF00);
      wait_drained();
   endtask

   task automatic test_every_op();
      write_csr(CSR_WIDTH, 16'd6);
      write_csr(CSR_HEIGHT, 16'd2);
      send_pixel(32'h0A14_1EFF);
      send_pixel(32'h0A14_1EFF);
      send_pixel(32'h0A14_1EFF);
      send_pixel(32'h0102_0304);
      send_pixel(32'h0A14_1EFF);
      send_pixel(32'hAA55_AA55);
      send_pixel(32'hFFFF_FFFF);
      repeat (5) send_pixel(32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      write_csr(CSR_WIDTH, 16'd16);
      write_csr(CSR_HEIGHT, 16'd2);
      rsp_hold_cycles = 200;
      repeat (32) send_pixel($urandom);
      wait_drained();
   endtask

   task automatic test_random_images();
      int              sent;
      int              w;
      int              h;
      int              k;
      int              run_left;
      int              mode;
      req_payload_type last_px;
      req_payload_type px;
      req_payload_type palette [4];
      sent     = 0;
      run_left = 0;
      last_px  = PIXEL_RESET;
      while (sent < RANDOM_PIXELS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 5) == 0) begin
            w = $urandom_range(40, 70);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end
         write_csr(CSR_WIDTH, 16'(w));
         write_csr(CSR_HEIGHT, 16'(h));
         foreach (palette[i]) palette[i] = $urandom;
         for (k = 0; k < w * h; k++) begin
            if (run_left > 0) begin
               px = last_px;
               run_left--;
            end else begin
               mode = $urandom_range(0, 11);
               if (mode < 4) px = last_px;
               else if (mode < 6) px = palette[$urandom_range(0, 3)];
               else if (mode < 8) px = {8'($urandom), 8'($urandom), 8'($urandom), last_px.alpha};
               else if (mode < 10) px = $urandom;
               else if (mode == 10) px = PIXEL_RESET;
               else begin
                  px       = last_px;
                  run_left = $urandom_range(55, 70);
               end
            end
            send_pixel(px);
            last_px = px;
            sent++;
         end
         wait_drained();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_WIDTH;
      csr_wdata       = '0;
      idle_on         = 1'b1;
      rsp_hold_cycles = 0;
      mismatches      = 0;
      cycle_count     = 0;
      img_width       = 16'd1;
      img_height      = 16'd1;
      clear_image();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_dimension_extremes();
      test_every_op();
      test_backpressure();
      test_random_images();
      wait_drained();

      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
